[rtl/fdrpc_pkg.sv]
// ----------------------------------------------------------------------------
// fdrpc_pkg
// shared types, constants and the sine table for the 4d rotate/project block
// ----------------------------------------------------------------------------
package fdrpc_pkg;

  localparam int SINE_TABLE_BITS = 8;
  localparam int TABLE_LEN       = 1 << SINE_TABLE_BITS;
  localparam int QUOT_BITS       = 34;
  localparam int NUM_LANES       = 3;

  typedef logic signed [17:0] trig_t;
  typedef trig_t sin_table_t [TABLE_LEN];

  typedef enum logic [2:0] {
    REG_ANGLE_XW = 3'd0,
    REG_ANGLE_YW = 3'd1,
    REG_ANGLE_ZW = 3'd2,
    REG_W_SCALE  = 3'd3,
    REG_W_UPPER  = 3'd4,
    REG_W_LOWER  = 3'd5
  } cfg_reg_e;

  localparam logic [63:0] PI_Q32  = 64'd13493037705;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] SIN_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
  localparam logic [63:0] COS_DIV [6] = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

  // one divider lane word
  typedef struct packed {
    logic [32:0]        rem;
    logic [33:0]        num;
    logic [33:0]        quo;
    logic               neg;
    logic signed [31:0] guard_val;
  } div_lane_t;

  // per item data riding along the divider
  typedef struct packed {
    logic [32:0] pm;
    logic        guard;
    logic        outside;
    logic [16:0] alpha;
  } div_side_t;

  // sine of a 16 bit phase in signed q2.16, taylor series on the reduced angle
  function automatic trig_t sine_q16(input logic [15:0] phase);
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] v;
    logic [63:0] m;
    logic [1:0]  q;
    q = phase[15:14];
    r = {50'd0, phase[13:0]};
    if (q[0]) begin
      r = 64'd16384 - r;
    end
    h = ONE_Q30;
    if (r <= 64'd8192) begin
      t  = (r * PI_Q32 + 64'd65536) >> 17;
      x2 = (t * t) >> 30;
      for (int i = 0; i < 5; i++) begin
        h = ONE_Q30 - ((x2 * h) >> 30) / SIN_DIV[i];
      end
      v = (t * h) >> 30;
    end else begin
      t  = ((64'd16384 - r) * PI_Q32 + 64'd65536) >> 17;
      x2 = (t * t) >> 30;
      for (int i = 0; i < 6; i++) begin
        h = ONE_Q30 - ((x2 * h) >> 30) / COS_DIV[i];
      end
      v = h;
    end
    m = (v + 64'd8192) >> 14;
    return q[1] ? trig_t'(-m[17:0]) : trig_t'(m[17:0]);
  endfunction

  function automatic sin_table_t build_sin_table();
    sin_table_t tbl;
    for (int k = 0; k < TABLE_LEN; k++) begin
      tbl[k] = sine_q16(16'(k << (16 - SINE_TABLE_BITS)));
    end
    return tbl;
  endfunction

  localparam sin_table_t SIN_TABLE = build_sin_table();

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -48'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // (a +/- b + half) >>> 16, saturated
  function automatic logic signed [31:0] rnd_mac(input logic signed [49:0] a,
                                                  input logic signed [49:0] b,
                                                  input logic sub);
    logic signed [50:0] s;
    s = sub ? (51'(a) - 51'(b) + 51'sd32768) : (51'(a) + 51'(b) + 51'sd32768);
    return sat32(48'(s >>> 16));
  endfunction

endpackage

[rtl/four_d_rotate_project_clip_top.sv]
// ----------------------------------------------------------------------------
// four_d_rotate_project_clip_top
// 4d point rotation, perspective projection and window shrink, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   a point word (coord_x/y/z/w) is taken at a rising edge with start_i high;
//   busy_o stays low, so one point can be taken every clock
//   results leave on out_x/y/z and outside_window with valid_o high for one
//   cycle once the point has passed every stage; a point that lay outside the
//   window and shrank to exactly zero gives no result word
//   throughput is one point per clock: three rotation planes of multiply and
//   round stages, then a 34 stage restoring divider (one quotient bit per
//   stage, three lanes side by side) sets the latency
//   configuration words go through cfg_valid_i/cfg_ready_o with cfg_index_i
//   choosing the register; ready is always high; an angle write looks up its
//   sine and cosine in the table at once, so the table is off the data path
//   reset clears all valid bits and loads the register defaults (angles zero,
//   scale one, window wide open); the receiver cannot stall, the pipe
//   never holds
// ----------------------------------------------------------------------------
module four_d_rotate_project_clip_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic signed [31:0] coord_w_i,
  output logic               valid_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               outside_window_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int IDX_W = fdrpc_pkg::SINE_TABLE_BITS;
  localparam int QB    = fdrpc_pkg::QUOT_BITS;
  localparam int NL    = fdrpc_pkg::NUM_LANES;

  // ---------------- configuration ----------------
  fdrpc_pkg::trig_t   sa_q, ca_q, sb_q, cb_q, sc_q, cc_q;
  logic signed [31:0] w_scale_q, w_upper_q, w_lower_q;
  logic [IDX_W-1:0]   ang_idx, cos_idx;
  fdrpc_pkg::trig_t   ang_sin, ang_cos;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // sine at the angle, cosine a quarter turn further
  assign ang_idx = cfg_data_i[15 -: IDX_W];
  assign cos_idx = ang_idx + IDX_W'(fdrpc_pkg::TABLE_LEN / 4);
  assign ang_sin = fdrpc_pkg::SIN_TABLE[ang_idx];
  assign ang_cos = fdrpc_pkg::SIN_TABLE[cos_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q      <= '0;
      ca_q      <= 18'sd65536;
      sb_q      <= '0;
      cb_q      <= 18'sd65536;
      sc_q      <= '0;
      cc_q      <= 18'sd65536;
      w_scale_q <= 32'sd65536;
      w_upper_q <= 32'sh7fff_ffff;
      w_lower_q <= 32'sh8000_0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (fdrpc_pkg::cfg_reg_e'(cfg_index_i))
        fdrpc_pkg::REG_ANGLE_XW: begin
          sa_q <= ang_sin;
          ca_q <= ang_cos;
        end
        fdrpc_pkg::REG_ANGLE_YW: begin
          sb_q <= ang_sin;
          cb_q <= ang_cos;
        end
        fdrpc_pkg::REG_ANGLE_ZW: begin
          sc_q <= ang_sin;
          cc_q <= ang_cos;
        end
        fdrpc_pkg::REG_W_SCALE: w_scale_q <= cfg_data_i;
        fdrpc_pkg::REG_W_UPPER: w_upper_q <= cfg_data_i;
        fdrpc_pkg::REG_W_LOWER: w_lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- rotation stages ----------------
  logic               v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic signed [31:0] x0_q, y0_q, z0_q, w0_q;
  logic signed [31:0] x1_q, y1_q, x2_q, y2_q, z1_2_q, w1_2_q;
  logic signed [31:0] x3_q, z1_3_q, x4_q, z1_4_q, y2_4_q, w2_4_q;
  logic signed [31:0] x5_q, w2_5_q, x6_q, y3_6_q, z3_6_q;
  logic signed [49:0] pa1_q, pb1_q, pc1_q, pd1_q;
  logic signed [49:0] qa3_q, qb3_q, qc3_q, qd3_q;
  logic signed [49:0] ra5_q, rb5_q, rc5_q, rd5_q;
  logic signed [63:0] pw5_q;
  logic signed [33:0] p6_q;
  logic signed [47:0] sw6_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // input word
    x0_q <= coord_x_i;
    y0_q <= coord_y_i;
    z0_q <= coord_z_i;
    w0_q <= coord_w_i;
    // zw plane products
    x1_q  <= x0_q;
    y1_q  <= y0_q;
    pa1_q <= z0_q * ca_q;
    pb1_q <= w0_q * sa_q;
    pc1_q <= z0_q * sa_q;
    pd1_q <= w0_q * ca_q;
    // zw plane sums
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    z1_2_q <= fdrpc_pkg::rnd_mac(pa1_q, pb1_q, 1'b0);
    w1_2_q <= fdrpc_pkg::rnd_mac(pd1_q, pc1_q, 1'b1);
    // yw plane products
    x3_q   <= x2_q;
    z1_3_q <= z1_2_q;
    qa3_q  <= y2_q * cb_q;
    qb3_q  <= w1_2_q * sb_q;
    qc3_q  <= y2_q * sb_q;
    qd3_q  <= w1_2_q * cb_q;
    // yw plane sums
    x4_q   <= x3_q;
    z1_4_q <= z1_3_q;
    y2_4_q <= fdrpc_pkg::rnd_mac(qa3_q, qb3_q, 1'b1);
    w2_4_q <= fdrpc_pkg::rnd_mac(qc3_q, qd3_q, 1'b0);
    // yz plane products and w scale product
    x5_q   <= x4_q;
    w2_5_q <= w2_4_q;
    ra5_q  <= y2_4_q * cc_q;
    rb5_q  <= z1_4_q * sc_q;
    rc5_q  <= y2_4_q * sc_q;
    rd5_q  <= z1_4_q * cc_q;
    pw5_q  <= w2_4_q * w_scale_q;
    // yz plane sums, projection denominator, scaled w
    x6_q   <= x5_q;
    y3_6_q <= fdrpc_pkg::rnd_mac(ra5_q, rb5_q, 1'b0);
    z3_6_q <= fdrpc_pkg::rnd_mac(rd5_q, rc5_q, 1'b1);
    p6_q   <= 34'sd131072 - 34'(w2_5_q);
    sw6_q  <= 48'((pw5_q + 64'sd32768) >>> 16);
  end

  // ---------------- divider set-up and window test ----------------
  logic                  gneg, gpos, above, below;
  logic [33:0]           pmag;
  logic signed [48:0]    diff_up, diff_lo;
  logic [16:0]           alpha_d;
  logic signed [31:0]    lane_c [NL];
  fdrpc_pkg::div_lane_t  lane_d [NL];
  fdrpc_pkg::div_side_t  side_d;

  assign lane_c[0] = x6_q;
  assign lane_c[1] = y3_6_q;
  assign lane_c[2] = z3_6_q;

  // guard band around p = 0
  assign gneg = !p6_q[33] && (p6_q < 34'sd16384);
  assign gpos = p6_q[33] && (p6_q > -34'sd16384);
  assign pmag = p6_q[33] ? 34'(-p6_q) : 34'(p6_q);

  assign diff_up = 49'(sw6_q) - 49'(w_upper_q);
  assign diff_lo = 49'(w_lower_q) - 49'(sw6_q);
  assign above   = sw6_q > 48'(w_upper_q);
  assign below   = sw6_q < 48'(w_lower_q);

  always_comb begin
    priority if (above) begin
      alpha_d = (diff_up > 49'sd65536) ? 17'd65536 : diff_up[16:0];
    end else if (below) begin
      alpha_d = (diff_lo > 49'sd65536) ? 17'd65536 : diff_lo[16:0];
    end else begin
      alpha_d = '0;
    end
  end

  always_comb begin
    side_d.pm      = pmag[32:0];
    side_d.guard   = gneg || gpos;
    side_d.outside = above || below;
    side_d.alpha   = alpha_d;
  end

  for (genvar l = 0; l < NL; l++) begin : g_setup
    logic [31:0]        mag;
    logic [47:0]        num;
    logic signed [47:0] c4;
    assign mag = lane_c[l][31] ? 32'(-lane_c[l]) : 32'(lane_c[l]);
    // rounding half away from zero: add half the divisor to the magnitude
    assign num = {mag, 16'd0} + 48'(pmag >> 1);
    assign c4  = 48'(lane_c[l]) <<< 2;
    always_comb begin
      lane_d[l].rem       = 33'(num[47:34]);
      lane_d[l].num       = num[33:0];
      lane_d[l].quo       = '0;
      lane_d[l].neg       = lane_c[l][31] != p6_q[33];
      lane_d[l].guard_val = fdrpc_pkg::sat32(gneg ? -c4 : c4);
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  fdrpc_pkg::div_lane_t dl_q [QB+1][NL];
  fdrpc_pkg::div_side_t ds_q [QB+1];
  logic                 dv_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ds_q[0] <= side_d;
    for (int l = 0; l < NL; l++) begin
      dl_q[0][l] <= lane_d[l];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      ds_q[k+1] <= ds_q[k];
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [33:0] trial;
      logic        fits;
      assign trial = {dl_q[k][l].rem, dl_q[k][l].num[33]};
      assign fits  = trial >= {1'b0, ds_q[k].pm};
      always_ff @(posedge clk_i) begin
        dl_q[k+1][l].rem       <= fits ? 33'(trial - {1'b0, ds_q[k].pm}) : trial[32:0];
        dl_q[k+1][l].num       <= {dl_q[k][l].num[32:0], 1'b0};
        dl_q[k+1][l].quo       <= {dl_q[k][l].quo[32:0], fits};
        dl_q[k+1][l].neg       <= dl_q[k][l].neg;
        dl_q[k+1][l].guard_val <= dl_q[k][l].guard_val;
      end
    end
  end

  // ---------------- sign, saturation, shrink ----------------
  logic               vf1_q, vf2_q, valid_q;
  logic signed [31:0] proj_q [NL];
  logic               out_f1_q, out_f2_q;
  logic [16:0]        alpha_f1_q;
  logic signed [49:0] shr_q [NL];
  logic signed [31:0] shrunk [NL];
  logic signed [31:0] proj_d [NL];
  logic               all_zero;

  for (genvar l = 0; l < NL; l++) begin : g_fin
    logic signed [47:0] qs;
    assign qs        = $signed({14'd0, dl_q[QB][l].quo});
    assign proj_d[l] = ds_q[QB].guard ? dl_q[QB][l].guard_val
                                       : fdrpc_pkg::sat32(dl_q[QB][l].neg ? -qs : qs);
    assign shrunk[l] = 32'((shr_q[l] + 50'sd32768) >>> 16);
  end

  assign all_zero = (shrunk[0] == '0) && (shrunk[1] == '0) && (shrunk[2] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf1_q   <= 1'b0;
      vf2_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      vf1_q   <= dv_q[QB];
      vf2_q   <= vf1_q;
      // a shrunk point that lands on the origin is dropped
      valid_q <= vf2_q && !(out_f2_q && all_zero);
    end
  end

  always_ff @(posedge clk_i) begin
    out_f1_q   <= ds_q[QB].outside;
    alpha_f1_q <= ds_q[QB].alpha;
    out_f2_q   <= out_f1_q;
    for (int l = 0; l < NL; l++) begin
      proj_q[l] <= proj_d[l];
      // inside the window alpha is zero and the shrink is exact
      shr_q[l]  <= proj_q[l] * $signed({1'b0, 17'(18'd65536 - 18'(alpha_f1_q))});
    end
    out_x_o          <= shrunk[0];
    out_y_o          <= shrunk[1];
    out_z_o          <= shrunk[2];
    outside_window_o <= out_f2_q;
  end

  assign valid_o = valid_q;

  // ---------------- checks ----------------
  a_no_zero_shrunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && outside_window_o |-> (out_x_o != '0 || out_y_o != '0 || out_z_o != '0))
    else $error("shrunk point at origin was not dropped");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vf2_q |=> !valid_o)
    else $error("result word without an item in the last stage");

  a_scale_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == fdrpc_pkg::REG_W_SCALE)
    |=> w_scale_q == $past(cfg_data_i))
    else $error("scale register write lost");

endmodule

[tb/sv/four_d_rotate_project_clip_checker.sv]
// ----------------------------------------------------------------------------
// four_d_rotate_project_clip_checker
// predicts each projected point from the accepted input words and the
// configuration it has seen written, then compares every result word
// ----------------------------------------------------------------------------
module four_d_rotate_project_clip_checker
  import fdrpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic signed [31:0] coord_w_i,
  input  logic               valid_i,
  input  logic signed [31:0] out_x_i,
  input  logic signed [31:0] out_y_i,
  input  logic signed [31:0] out_z_i,
  input  logic               outside_window_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 pending_o,
  output int                 failures_o,
  output int                 checked_o,
  output int                 shrunk_o,
  output int                 dropped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               outside;
  } point_t;

  point_t projected_q[$];

  logic [15:0]        ang_xw, ang_yw, ang_zw;
  logic signed [31:0] win_scale, win_upper, win_lower;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // sine of a 16 bit phase in q16.16, series on the angle folded to [0, pi/4]
  function automatic longint phase_sine(input logic [15:0] phase);
    longint unsigned sdiv [5] = '{110, 72, 42, 20, 6};
    longint unsigned cdiv [6] = '{132, 90, 56, 30, 12, 2};
    longint unsigned one, r, t, x2, h, v;
    longint m;
    one = 64'd1 << 30;
    r = phase[13:0];
    if (phase[14]) r = 64'd16384 - r;
    h = one;
    if (r <= 64'd8192) begin
      t  = (r * 64'd13493037705 + 64'd65536) >> 17;
      x2 = (t * t) >> 30;
      for (int k = 0; k < 5; k++) h = one - ((x2 * h) >> 30) / sdiv[k];
      v = (t * h) >> 30;
    end else begin
      t  = ((64'd16384 - r) * 64'd13493037705 + 64'd65536) >> 17;
      x2 = (t * t) >> 30;
      for (int k = 0; k < 6; k++) h = one - ((x2 * h) >> 30) / cdiv[k];
      v = h;
    end
    m = longint'((v + 64'd8192) >> 14);
    return phase[15] ? -m : m;
  endfunction

  function automatic void angle_trig(input logic [15:0] angle, output longint s,
                                     output longint c);
    logic [15:0] phase;
    phase = (angle >> (16 - SINE_TABLE_BITS)) << (16 - SINE_TABLE_BITS);
    s = phase_sine(phase);
    c = phase_sine(phase + 16'd16384);
  endfunction

  function automatic longint plane_mac(input longint a, input longint ca,
                                       input longint b, input longint cb);
    return clamp32((a * ca + b * cb + 32768) >>> 16);
  endfunction

  // divide by p with round half away, guard band replaced by a fixed scale
  function automatic longint persp(input longint c, input longint p);
    longint num, mag, pm, q;
    if (p >= 0 && p < 16384) return clamp32(c * -4);
    if (p < 0 && p > -16384) return clamp32(c * 4);
    num = c * 65536;
    mag = num < 0 ? -num : num;
    pm  = p < 0 ? -p : p;
    q   = (mag + pm / 2) / pm;
    return clamp32(((num < 0) != (p < 0)) ? -q : q);
  endfunction

  function automatic longint pull_in(input longint v, input longint alpha);
    return (v * (65536 - alpha) + 32768) >>> 16;
  endfunction

  function automatic bit project_point(input logic signed [31:0] x, y, z, w,
                                       output point_t res);
    longint sa, ca, sb, cb, sc, cc, z1, w1, y2, w2, y3, z3;
    longint px, py, pz, p, sw, alpha;
    bit outside;
    angle_trig(ang_xw, sa, ca);
    angle_trig(ang_yw, sb, cb);
    angle_trig(ang_zw, sc, cc);
    z1 = plane_mac(longint'(z), ca, longint'(w), sa);
    w1 = plane_mac(longint'(z), -sa, longint'(w), ca);
    y2 = plane_mac(longint'(y), cb, w1, -sb);
    w2 = plane_mac(longint'(y), sb, w1, cb);
    y3 = plane_mac(y2, cc, z1, sc);
    z3 = plane_mac(y2, -sc, z1, cc);
    p  = 131072 - w2;
    px = persp(longint'(x), p);
    py = persp(y3, p);
    pz = persp(z3, p);
    sw = (w2 * longint'(win_scale) + 32768) >>> 16;
    outside = 1'b0;
    alpha = 0;
    if (sw > longint'(win_upper)) begin
      outside = 1'b1;
      alpha = sw - longint'(win_upper);
    end else if (sw < longint'(win_lower)) begin
      outside = 1'b1;
      alpha = longint'(win_lower) - sw;
    end
    if (outside) begin
      if (alpha > 65536) alpha = 65536;
      px = pull_in(px, alpha);
      py = pull_in(py, alpha);
      pz = pull_in(pz, alpha);
      if (px == 0 && py == 0 && pz == 0) return 1'b0;
    end
    res.x = px[31:0];
    res.y = py[31:0];
    res.z = pz[31:0];
    res.outside = outside;
    return 1'b1;
  endfunction

  assign pending_o = projected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    point_t exp_pt;
    if (!rst_ni) begin
      ang_xw    <= '0;
      ang_yw    <= '0;
      ang_zw    <= '0;
      win_scale <= 32'sd65536;
      win_upper <= 32'sh7fff_ffff;
      win_lower <= 32'sh8000_0000;
      projected_q.delete();
      failures_o <= 0;
      checked_o  <= 0;
      shrunk_o   <= 0;
      dropped_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ANGLE_XW: ang_xw    <= cfg_data_i[15:0];
          REG_ANGLE_YW: ang_yw    <= cfg_data_i[15:0];
          REG_ANGLE_ZW: ang_zw    <= cfg_data_i[15:0];
          REG_W_SCALE:  win_scale <= cfg_data_i;
          REG_W_UPPER:  win_upper <= cfg_data_i;
          REG_W_LOWER:  win_lower <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (project_point(coord_x_i, coord_y_i, coord_z_i, coord_w_i, exp_pt)) begin
          projected_q = {projected_q, exp_pt};
          if (exp_pt.outside) shrunk_o <= shrunk_o + 1;
        end else begin
          dropped_o <= dropped_o + 1;
        end
      end
      if (valid_i) begin
        if (projected_q.size() == 0) begin
          $error("result word with none expected");
          failures_o <= failures_o + 1;
        end else begin
          exp_pt = projected_q.pop_front();
          checked_o <= checked_o + 1;
          if (out_x_i !== exp_pt.x || out_y_i !== exp_pt.y || out_z_i !== exp_pt.z ||
              outside_window_i !== exp_pt.outside) begin
            failures_o <= failures_o + 1;
            if (out_x_i !== exp_pt.x)
              $error("out_x expected %0d got %0d", exp_pt.x, out_x_i);
            if (out_y_i !== exp_pt.y)
              $error("out_y expected %0d got %0d", exp_pt.y, out_y_i);
            if (out_z_i !== exp_pt.z)
              $error("out_z expected %0d got %0d", exp_pt.z, out_z_i);
            if (outside_window_i !== exp_pt.outside)
              $error("outside_window expected %0d got %0d", exp_pt.outside,
                     outside_window_i);
          end
        end
      end
    end
  end

endmodule

[tb/sv/tb_four_d_rotate_project_clip_top.sv]
// ----------------------------------------------------------------------------
// tb_four_d_rotate_project_clip_top
// drives point words and configuration phases into the rotate/project block;
// the checker beside it predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_four_d_rotate_project_clip_top;
  import fdrpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it, writes must be ignored
  localparam logic [2:0] REG_NONE    = 3'd6;
  localparam int         DRAIN_CYC   = 60;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         NUM_PHASES  = 9;
  localparam int         PHASE_PTS   = 120;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0, coord_w_i = '0;
  logic               valid_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic               outside_window_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  int pending, failures, checked, shrunk, dropped;
  int cycles = 0;
  int points_sent = 0;
  bit no_idle;

  always #5 clk_i = ~clk_i;

  four_d_rotate_project_clip_top dut (.*);

  four_d_rotate_project_clip_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .coord_x_i, .coord_y_i, .coord_z_i, .coord_w_i,
    .valid_i(valid_o), .out_x_i(out_x_o), .out_y_i(out_y_o), .out_z_i(out_z_o),
    .outside_window_i(outside_window_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .failures_o(failures), .checked_o(checked),
    .shrunk_o(shrunk), .dropped_o(dropped)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_point(input logic signed [31:0] x, y, z, w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    coord_x_i = x;
    coord_y_i = y;
    coord_z_i = z;
    coord_w_i = w;
    start_i   = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    points_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // let every expected word come out, then cover points still in flight
  // that may have been dropped
  task automatic drain();
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  // mostly small coordinates so rotation and divide stay in range, w biased
  // around 2.0 to hit the guard band, some full width words
  function automatic logic signed [31:0] rand_coord(input bit near_two);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) return $urandom();
    if (near_two) return 32'sd131072 + $signed($urandom_range(0, 32'h20000)) - 32'sd65536;
    return $signed($urandom_range(0, 32'h80000)) - 32'sd262144;
  endfunction

  function automatic logic [31:0] rand_window(input bit wide);
    if (wide) return $urandom();
    return $signed($urandom_range(0, 32'h60000)) - 32'sd196608;
  endfunction

  initial begin
    logic [31:0] ph_cfg [NUM_PHASES][6];
    logic signed [31:0] edge_vals [4];
    logic signed [31:0] w_probe [6];

    edge_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1};
    // p exactly 0, just inside each side of the guard band, and on its limits
    w_probe   = '{32'sd131072, 32'sd131000, 32'sd131200, 32'sd114688,
                  32'sd147456, 32'sd114689};

    // angles, scale, upper, lower per phase; extremes first, then random
    ph_cfg[0] = '{32'h1234, 32'h4000, 32'hffff, 32'd65536, 32'd65536, 32'hffff_0000};
    ph_cfg[1] = '{32'hffff, 32'h8000, 32'h2000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000};
    ph_cfg[2] = '{32'h9abc, 32'h0100, 32'hc000, 32'h8000_0000, 32'd0, 32'd0};
    // inverted window
    ph_cfg[3] = '{32'h0, 32'hffff, 32'h0, 32'd32768, 32'd16384, 32'd32768};
    for (int p = 4; p < NUM_PHASES; p++) begin
      ph_cfg[p][0] = $urandom_range(0, 16'hffff);
      ph_cfg[p][1] = $urandom_range(0, 16'hffff);
      ph_cfg[p][2] = $urandom_range(0, 16'hffff);
      ph_cfg[p][3] = (p == 8) ? $urandom() : $signed($urandom_range(0, 32'h40000)) - 32'sd131072;
      ph_cfg[p][4] = rand_window(p == 8);
      ph_cfg[p][5] = rand_window(p == 8);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed words at reset settings: field extremes and the guard band
    no_idle = 1'b0;
    for (int i = 0; i < 4; i++)
      send_point(edge_vals[i], edge_vals[(i + 1) % 4], edge_vals[(i + 2) % 4],
                 edge_vals[(i + 3) % 4]);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    for (int i = 0; i < 6; i++)
      send_point(32'sd65536, -32'sd98304, 32'sd40000, w_probe[i]);
    drain();

    // a write to an unused index must change nothing
    write_reg(REG_NONE, 32'hdead_beef);
    for (int i = 0; i < 4; i++)
      send_point(32'sd65536, 32'sd65536, 32'sd65536, w_probe[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_ANGLE_XW, ph_cfg[p][0]);
      write_reg(REG_ANGLE_YW, ph_cfg[p][1]);
      write_reg(REG_ANGLE_ZW, ph_cfg[p][2]);
      write_reg(REG_W_SCALE,  ph_cfg[p][3]);
      write_reg(REG_W_UPPER,  ph_cfg[p][4]);
      write_reg(REG_W_LOWER,  ph_cfg[p][5]);
      // window phases get the same probe points, so shrink and drop show up
      for (int i = 0; i < 6; i++)
        send_point(32'sd8, -32'sd8, 32'sd4, w_probe[i]);
      for (int i = 0; i < PHASE_PTS; i++) begin
        // alternate back to back stretches with idle ones
        if (i % 40 == 0) no_idle = $urandom_range(0, 2) == 0;
        send_point(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                   rand_coord($urandom_range(0, 1)));
      end
      no_idle = 1'b0;
      drain();
    end

    $display("%0d points sent over %0d register settings, %0d results checked",
             points_sent, NUM_PHASES + 1, checked);
    $display("%0d results shrunk by the window, %0d points dropped", shrunk, dropped);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
